>>> hdl/epd_pkg.sv
// Package for the external power presence detector.
// Holds the word types, configuration types, register indexes and reset values.
// No dependencies.
package epd_pkg;

  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REG_POLL_INTERVAL = 2'd0,
    REG_BUS_PRESENT   = 2'd1,
    REG_BUS_ABSENT    = 2'd2,
    REG_PULSE_HOLD    = 2'd3
  } reg_idx_e;

  localparam int unsigned AddrWidth = 4;

  localparam logic [15:0] PollIntervalReset = 16'd250;
  localparam logic [15:0] BusPresentReset   = 16'd4000;
  localparam logic [15:0] BusAbsentReset    = 16'd3000;
  localparam logic [31:0] PulseHoldReset    = 32'd5000;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] now_ms;
    logic        charging_in;
    logic [15:0] battery_mv_in;
    logic [15:0] bus_mv_in;
  } in_word_t;

  typedef struct packed {
    logic        external_present;
    logic [15:0] battery_mv;
    logic [15:0] bus_mv;
    logic [31:0] max_pulse_gap_ms;
  } out_word_t;

  typedef struct packed {
    logic [15:0] poll_interval_ms;
    logic [15:0] bus_present_mv;
    logic [15:0] bus_absent_mv;
    logic [31:0] pulse_hold_ms;
  } cfg_t;

endpackage

>>> hdl/epd_in_if.sv
// Input channel of the external power presence detector.
// Depends on epd_pkg for the word type.
interface epd_in_if import epd_pkg::*; ();

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

>>> hdl/epd_out_if.sv
// Result channel of the external power presence detector.
// Depends on epd_pkg for the word type.
interface epd_out_if import epd_pkg::*; ();

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

>>> hdl/external_power_presence_detector.sv
// Top level of the external power presence detector.
// Depends on epd_pkg, epd_in_if, epd_out_if, epd_cfg and epd_decide.
//
// Usage:
// Input words arrive on in_if (valid/ready); each carries a kind (start or
// update), a millisecond timestamp and fresh charging, battery and bus
// readings. Every input word yields exactly one result word on out_if with
// the presence decision, the held readings and the largest pulse gap.
// A word is registered at acceptance, decided against the detector state once
// the result register is free, and then written to the result register. One
// word per cycle is sustained while the receiver takes every result; the state
// update of one word is registered at the same edge as its result, so the next
// word is decided against the updated state and no bubbles are needed.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; after that in_if.ready drops until the
// result is taken.
// Reset clears the detector state and both valid flags and loads the
// configuration registers with their defaults. The user must write them over the
// APB port only while the block is idle; the block itself does not enforce this. pready is always high.
module external_power_presence_detector import epd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  epd_in_if.sink               in_if,
  epd_out_if.source            out_if,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t      cfg;
  in_word_t  word_q;
  logic      word_valid_q, word_valid_d;
  out_word_t result;
  out_word_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      advance;
  logic      accept;

  assign pready = 1'b1;

  epd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign advance     = word_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !word_valid_q || advance;
  assign accept      = in_if.valid && in_if.ready;

  assign word_valid_d = accept || (word_valid_q && !advance);
  assign out_valid_d  = advance || (out_valid_q && !out_if.ready);

  epd_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .word_i   (word_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      word_valid_q <= word_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_if.data;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

endmodule

>>> hdl/epd_cfg.sv
// APB-style configuration registers of the external power presence detector.
// Depends on epd_pkg for register indexes, reset values and cfg_t.
module epd_cfg import epd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output cfg_t                 cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[AddrWidth-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_POLL_INTERVAL: cfg_d.poll_interval_ms = pwdata[15:0];
        REG_BUS_PRESENT:   cfg_d.bus_present_mv   = pwdata[15:0];
        REG_BUS_ABSENT:    cfg_d.bus_absent_mv    = pwdata[15:0];
        REG_PULSE_HOLD:    cfg_d.pulse_hold_ms    = pwdata;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POLL_INTERVAL: prdata = {16'd0, cfg_q.poll_interval_ms};
      REG_BUS_PRESENT:   prdata = {16'd0, cfg_q.bus_present_mv};
      REG_BUS_ABSENT:    prdata = {16'd0, cfg_q.bus_absent_mv};
      REG_PULSE_HOLD:    prdata = cfg_q.pulse_hold_ms;
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_interval_ms <= PollIntervalReset;
      cfg_q.bus_present_mv   <= BusPresentReset;
      cfg_q.bus_absent_mv    <= BusAbsentReset;
      cfg_q.pulse_hold_ms    <= PulseHoldReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/epd_decide.sv
// Detector state and the combinational decision logic for one input word.
// Depends on epd_pkg for the word and configuration types.
module epd_decide import epd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_word_t  word_i,
  input  cfg_t      cfg_i,
  output out_word_t result_o
);

  logic [31:0] last_poll_q, last_poll_d;
  logic [31:0] last_pulse_q, last_pulse_d;
  logic [31:0] largest_gap_q, largest_gap_d;
  logic        trusted_q, trusted_d;
  logic        present_q, present_d;
  logic        seen_pulse_q, seen_pulse_d;
  logic        charging_q, charging_d;
  logic [15:0] battery_q, battery_d;
  logic [15:0] bus_q, bus_d;

  logic [31:0] poll_elapsed;
  logic [31:0] pulse_gap;
  logic        poll_due;
  logic        bus_high;
  logic        bus_low;
  logic        gap_in_hold;

  assign poll_elapsed = word_i.now_ms - last_poll_q;
  assign pulse_gap    = word_i.now_ms - last_pulse_q;
  assign poll_due     = poll_elapsed >= {16'd0, cfg_i.poll_interval_ms};
  assign bus_high     = word_i.bus_mv_in >= cfg_i.bus_present_mv;
  assign bus_low      = word_i.bus_mv_in < cfg_i.bus_absent_mv;
  assign gap_in_hold  = pulse_gap < cfg_i.pulse_hold_ms;

  always_comb begin
    last_poll_d   = last_poll_q;
    last_pulse_d  = last_pulse_q;
    largest_gap_d = largest_gap_q;
    trusted_d     = trusted_q;
    present_d     = present_q;
    seen_pulse_d  = seen_pulse_q;
    charging_d    = charging_q;
    battery_d     = battery_q;
    bus_d         = bus_q;
    if (word_i.kind == KIND_START) begin
      charging_d    = word_i.charging_in;
      battery_d     = word_i.battery_mv_in;
      bus_d         = word_i.bus_mv_in;
      trusted_d     = bus_high;
      present_d     = bus_high || word_i.charging_in;
      last_pulse_d  = word_i.now_ms;
      last_poll_d   = word_i.now_ms;
      largest_gap_d = 32'd0;
      seen_pulse_d  = word_i.charging_in;
    end else if (poll_due) begin
      last_poll_d = word_i.now_ms;
      charging_d  = word_i.charging_in;
      battery_d   = word_i.battery_mv_in;
      bus_d       = word_i.bus_mv_in;
      if (bus_high) begin
        trusted_d = 1'b1;
        present_d = 1'b1;
      end else if (trusted_q) begin
        if (bus_low) begin
          present_d = 1'b0;
        end
      end else if (word_i.charging_in) begin
        if (seen_pulse_q && pulse_gap > largest_gap_q && gap_in_hold) begin
          largest_gap_d = pulse_gap;
        end
        last_pulse_d = word_i.now_ms;
        seen_pulse_d = 1'b1;
        present_d    = 1'b1;
      end else if (!(seen_pulse_q && gap_in_hold)) begin
        present_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_poll_q   <= 32'd0;
      last_pulse_q  <= 32'd0;
      largest_gap_q <= 32'd0;
      trusted_q     <= 1'b0;
      present_q     <= 1'b0;
      seen_pulse_q  <= 1'b0;
      charging_q    <= 1'b0;
      battery_q     <= 16'd0;
      bus_q         <= 16'd0;
    end else if (en_i) begin
      last_poll_q   <= last_poll_d;
      last_pulse_q  <= last_pulse_d;
      largest_gap_q <= largest_gap_d;
      trusted_q     <= trusted_d;
      present_q     <= present_d;
      seen_pulse_q  <= seen_pulse_d;
      charging_q    <= charging_d;
      battery_q     <= battery_d;
      bus_q         <= bus_d;
    end
  end

  always_comb begin
    result_o.external_present = present_d;
    result_o.battery_mv       = battery_d;
    result_o.bus_mv           = bus_d;
    result_o.max_pulse_gap_ms = largest_gap_d;
  end

endmodule

>>> hdl/epd_chk.sv
// Port-level checker for the external power presence detector.
// Depends on epd_pkg; bound to the top level by the bind statement below.
module epd_chk import epd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word dropped or changed while stalled");

  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result word appeared without an input word two cycles earlier");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && $past(in_valid_i && in_ready_i)
      && $past(out_valid_i && !out_ready_i) |-> !in_ready_i)
    else $error("input accepted while both registers are full");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !$past(in_valid_i && in_ready_i) |-> in_ready_i)
    else $error("input not ready although the block is empty");

endmodule

bind external_power_presence_detector epd_chk u_epd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);
